>>> design/ple_pkg.sv
// Shared codes and field widths for the positional list engine.
`default_nettype none

package ple_pkg;

    // Field widths of one beat
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 9;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned LEN_W   = 9;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 48;

    typedef logic [FUNC_W-1:0]  t_func;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [STAT_W-1:0]  t_stat;
    typedef logic [LEN_W-1:0]   t_len;

    // Operation codes
    localparam t_func FN_INS_FRONT = 3'd0;
    localparam t_func FN_INS_BACK  = 3'd1;
    localparam t_func FN_INS_AT    = 3'd2;
    localparam t_func FN_REM_FRONT = 3'd3;
    localparam t_func FN_REM_BACK  = 3'd4;
    localparam t_func FN_REM_AT    = 3'd5;

    // Status codes
    localparam t_stat STAT_OK     = 2'd0;
    localparam t_stat STAT_EMPTY  = 2'd1;
    localparam t_stat STAT_BADPOS = 2'd2;
    localparam t_stat STAT_FULL   = 2'd3;

endpackage

`default_nettype wire

>>> design/ple_ram.sv
// Simple dual-port RAM, one write port, one read port with registered read data.
`default_nettype none

module ple_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/positional_list_engine.sv
// Top level of the positional list engine: bounded ordered list with indexed insert/remove.
// A beat that fails its checks (empty, full, bad position, unused code) has its result
//   registered in the cycle after acceptance. Insert or remove at index i shifts the
//   entries between i and the end of the list by one slot, reading and writing the RAM.
// Throughput: one item at a time; a new beat is taken when idle and the output is free.
// Reset: synchronous active-low; clears the entry count, sequencer and output valid. RAM
//   contents are left as they are, since only entries below the count are ever read.
`default_nettype none

module positional_list_engine #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side: func [2:0], value [34:3], position [43:35], zero [47:44]
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,
    // master side: removed_value [31:0], status [33:32], length [42:34], zero [47:43]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata
);

    // Address width of the store and width of a count that can reach DEPTH
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    // Compare width covering both the count and the 9-bit position field
    localparam int unsigned CMPW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;   // waiting for a beat
    localparam logic [1:0] S_INS  = 2'd1;   // shifting entries up, then writing the new value
    localparam logic [1:0] S_REM  = 2'd2;   // reading the victim, then shifting entries down

    // Unpacked input fields
    ple_pkg::t_func  w_func;
    ple_pkg::t_value w_value;
    ple_pkg::t_pos   w_pos;

    assign w_func  = i_s_tdata[2:0];
    assign w_value = i_s_tdata[34:3];
    assign w_pos   = i_s_tdata[43:35];

    // Control state
    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt,   n_cnt;     // entries in use
    logic [CW-1:0] r_ptr,   n_ptr;     // shift pointer
    logic [CW-1:0] r_idx,   n_idx;     // target index of the current item
    logic          r_pend,  n_pend;    // a RAM read was issued last cycle
    logic          r_pfirst, n_pfirst; // that read was the removed entry itself
    logic          r_first, n_first;   // next read in S_REM is the removed entry
    logic          r_ovalid, n_ovalid;

    // Payload state
    logic [AW-1:0]      r_wa,  n_wa;   // write address for the pending read data
    ple_pkg::t_value    r_val, n_val;  // value to insert
    ple_pkg::t_value    r_got, n_got;  // value taken out
    ple_pkg::t_value    r_o_value, n_o_value;
    ple_pkg::t_stat     r_o_status, n_o_status;
    ple_pkg::t_len      r_o_length, n_o_length;

    // RAM port
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    ple_pkg::t_value    ram_wdata;
    ple_pkg::t_value    ram_rdata;

    logic            s_accept;
    logic            m_take;
    logic [CMPW-1:0] w_cnt_ext;
    logic [CMPW-1:0] w_pos_ext;
    logic [CMPW-1:0] w_ins_pos;
    logic [CMPW-1:0] w_rem_pos;
    logic            w_full;

    // A new beat is taken only when idle and the output register is free by this edge
    assign o_s_tready = (r_state == S_IDLE) && (!r_ovalid || i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign m_take     = r_ovalid && i_m_tready;

    assign w_cnt_ext = CMPW'(r_cnt);
    assign w_pos_ext = CMPW'(w_pos);
    assign w_full    = (r_cnt == CW'(DEPTH));

    // Index each operation targets; back of the list depends on the count
    always_comb begin
        case (w_func)
            ple_pkg::FN_INS_FRONT: w_ins_pos = '0;
            ple_pkg::FN_INS_BACK:  w_ins_pos = w_cnt_ext;
            default:               w_ins_pos = w_pos_ext;
        endcase
        case (w_func)
            ple_pkg::FN_REM_FRONT: w_rem_pos = '0;
            ple_pkg::FN_REM_BACK:  w_rem_pos = (r_cnt == '0) ? '0 : w_cnt_ext - CMPW'(1);
            default:               w_rem_pos = w_pos_ext;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ptr      = r_ptr;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pfirst   = r_pfirst;
        n_first    = r_first;
        n_ovalid   = r_ovalid;
        n_wa       = r_wa;
        n_val      = r_val;
        n_got      = r_got;
        n_o_value  = r_o_value;
        n_o_status = r_o_status;
        n_o_length = r_o_length;

        ram_we    = 1'b0;
        ram_waddr = r_wa;
        ram_wdata = ram_rdata;
        ram_raddr = '0;

        if (m_take) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_val      = w_value;
                    n_first    = 1'b1;
                    n_pend     = 1'b0;
                    n_pfirst   = 1'b0;
                    // Default: the item ends here with an error status
                    n_o_value  = '0;
                    n_o_length = ple_pkg::LEN_W'(r_cnt);
                    case (w_func)
                        ple_pkg::FN_INS_FRONT, ple_pkg::FN_INS_BACK,
                        ple_pkg::FN_INS_AT: begin
                            if (w_ins_pos > w_cnt_ext) begin
                                n_ovalid   = 1'b1;
                                n_o_status = ple_pkg::STAT_BADPOS;
                            end else if (w_full) begin
                                n_ovalid   = 1'b1;
                                n_o_status = ple_pkg::STAT_FULL;
                            end else begin
                                n_idx   = CW'(w_ins_pos);
                                n_ptr   = r_cnt;
                                n_state = S_INS;
                            end
                        end
                        ple_pkg::FN_REM_FRONT, ple_pkg::FN_REM_BACK,
                        ple_pkg::FN_REM_AT: begin
                            if (r_cnt == '0) begin
                                n_ovalid   = 1'b1;
                                n_o_status = ple_pkg::STAT_EMPTY;
                            end else if (w_rem_pos >= w_cnt_ext) begin
                                n_ovalid   = 1'b1;
                                n_o_status = ple_pkg::STAT_BADPOS;
                            end else begin
                                n_idx   = CW'(w_rem_pos);
                                n_ptr   = CW'(w_rem_pos);
                                n_state = S_REM;
                            end
                        end
                        default: begin
                            n_ovalid   = 1'b1;
                            n_o_status = ple_pkg::STAT_BADPOS;
                        end
                    endcase
                end
            end

            S_INS: begin
                // Write back what was read last cycle one slot higher
                ram_we    = r_pend;
                ram_waddr = r_wa;
                ram_wdata = ram_rdata;
                if (r_ptr != r_idx) begin
                    ram_raddr = AW'(r_ptr - CW'(1));
                    n_pend    = 1'b1;
                    n_wa      = AW'(r_ptr);
                    n_ptr     = r_ptr - CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        // Gap is open: drop the new value in
                        ram_we     = 1'b1;
                        ram_waddr  = AW'(r_idx);
                        ram_wdata  = r_val;
                        n_cnt      = r_cnt + CW'(1);
                        n_ovalid   = 1'b1;
                        n_o_value  = '0;
                        n_o_status = ple_pkg::STAT_OK;
                        n_o_length = ple_pkg::LEN_W'(r_cnt + CW'(1));
                        n_state    = S_IDLE;
                    end
                end
            end

            S_REM: begin
                // First read returns the victim; later reads move one slot lower
                if (r_pend) begin
                    if (r_pfirst) begin
                        n_got = ram_rdata;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_wa;
                        ram_wdata = ram_rdata;
                    end
                end
                if (r_ptr != r_cnt) begin
                    ram_raddr = AW'(r_ptr);
                    n_pend    = 1'b1;
                    n_pfirst  = r_first;
                    n_first   = 1'b0;
                    n_wa      = AW'(r_ptr - CW'(1));
                    n_ptr     = r_ptr + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_cnt      = r_cnt - CW'(1);
                        n_ovalid   = 1'b1;
                        n_o_value  = r_got;
                        n_o_status = ple_pkg::STAT_OK;
                        n_o_length = ple_pkg::LEN_W'(r_cnt - CW'(1));
                        n_state    = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ptr    <= '0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_pfirst <= 1'b0;
            r_first  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ptr    <= n_ptr;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_pfirst <= n_pfirst;
            r_first  <= n_first;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa       <= n_wa;
        r_val      <= n_val;
        r_got      <= n_got;
        r_o_value  <= n_o_value;
        r_o_status <= n_o_status;
        r_o_length <= n_o_length;
    end

    // Entry store
    ple_ram #(
        .WIDTH (ple_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_o_length, r_o_status, r_o_value};

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count above depth");

    a_we_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state != S_IDLE))
        else $error("RAM write while idle");

    a_ins_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_ptr >= r_idx) && (r_cnt < CW'(DEPTH)))
        else $error("insert shift pointer out of range");

    a_rem_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REM) |-> (r_ptr <= r_cnt) && (r_idx < r_cnt))
        else $error("remove shift pointer out of range");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_ovalid)
        else $error("result pending while an item is in work");
`endif

endmodule

`default_nettype wire
